// ===== hdl/spsg_pkg.sv =====
// Package for the scan proximity safety gate: widths, codes, payload and bundle types.
// Used by every file of the block; depends on nothing.
package spsg_pkg;

  localparam int unsigned RANGE_W    = 17;
  localparam int unsigned VEL_W      = 16;
  localparam int unsigned STEPS_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned MAX_SAMPLES_DEF = 2048;
  localparam int unsigned SIDE_MARGIN_DEF = 50;

  localparam logic [RANGE_W-1:0] NO_RANGE_MM     = 17'd100000;
  localparam logic [RANGE_W-1:0] THRESHOLD_RST   = 17'd500;
  localparam logic [STEPS_W-1:0] BACKUP_STEPS_RST = 8'd10;
  localparam logic [RANGE_W-1:0] MIN_VALID_RST   = 17'd0;
  localparam logic signed [VEL_W-1:0] REVERSE_MMS = -16'sd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_BACKUP_STEPS = 2'd1,
    CFG_MIN_VALID    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_CMD   = 1'b0,
    REQ_RANGE = 1'b1
  } req_type_e;

  typedef enum logic {
    KIND_DRIVE = 1'b0,
    KIND_INFO  = 1'b1
  } out_kind_e;

  typedef enum logic [1:0] {
    SIDE_FRONT = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  // What one result of a bundle is.
  typedef enum logic [1:0] {
    SLOT_PASS    = 2'd0,
    SLOT_REVERSE = 2'd1,
    SLOT_STOP    = 2'd2,
    SLOT_INFO    = 2'd3
  } slot_e;

  typedef struct packed {
    logic                      req_type;
    logic [RANGE_W-1:0]        range_sample;
    logic                      scan_end;
    logic signed [VEL_W-1:0]   cmd_lin_x;
    logic signed [VEL_W-1:0]   cmd_lin_y;
    logic signed [VEL_W-1:0]   cmd_lin_z;
    logic signed [VEL_W-1:0]   cmd_ang_x;
    logic signed [VEL_W-1:0]   cmd_ang_y;
    logic signed [VEL_W-1:0]   cmd_ang_z;
  } req_t;

  typedef struct packed {
    logic                      out_kind;
    logic signed [VEL_W-1:0]   drive_lin_x;
    logic signed [VEL_W-1:0]   drive_lin_y;
    logic signed [VEL_W-1:0]   drive_lin_z;
    logic signed [VEL_W-1:0]   drive_ang_x;
    logic signed [VEL_W-1:0]   drive_ang_y;
    logic signed [VEL_W-1:0]   drive_ang_z;
    logic [RANGE_W-1:0]        nearest_mm;
    logic [RANGE_W-1:0]        threshold_echo;
    logic [1:0]                obstacle_side;
    logic                      run_last;
  } res_t;

  typedef struct packed {
    logic [RANGE_W-1:0] threshold;
    logic [STEPS_W-1:0] backup_steps;
    logic [RANGE_W-1:0] min_valid;
  } cfg_t;

  // All results caused by one item: up to three, in slot order.
  typedef struct packed {
    logic [1:0]                cnt;
    slot_e [2:0]               slot;
    logic signed [VEL_W-1:0]   lin_x;
    logic signed [VEL_W-1:0]   lin_y;
    logic signed [VEL_W-1:0]   lin_z;
    logic signed [VEL_W-1:0]   ang_x;
    logic signed [VEL_W-1:0]   ang_y;
    logic signed [VEL_W-1:0]   ang_z;
    logic [RANGE_W-1:0]        nearest;
    logic [RANGE_W-1:0]        threshold;
    side_e                     side;
  } bundle_t;

endpackage

// ===== hdl/spsg_if.sv =====
// Handshake channels of the scan proximity safety gate: request and result items.
// Depends on spsg_pkg for the payload types.
interface spsg_req_if;
  logic          valid;
  logic          ready;
  spsg_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spsg_res_if;
  logic          valid;
  logic          ready;
  spsg_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/spsg_cfg_regs.sv =====
// Configuration registers of the scan proximity safety gate.
// Depends on spsg_pkg for widths, register indexes and reset values.
module spsg_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spsg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spsg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output spsg_pkg::cfg_t                   cfg_o
);
  import spsg_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic [STEPS_W-1:0] steps_wr;

  // A zero step count is stored as one so a backup always ends.
  assign steps_wr = (cfg_data_i[STEPS_W-1:0] == '0) ? STEPS_W'(1) : cfg_data_i[STEPS_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:    cfg_d.threshold    = cfg_data_i[RANGE_W-1:0];
        CFG_BACKUP_STEPS: cfg_d.backup_steps = steps_wr;
        CFG_MIN_VALID:    cfg_d.min_valid    = cfg_data_i[RANGE_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= THRESHOLD_RST;
      cfg_q.backup_steps <= BACKUP_STEPS_RST;
      cfg_q.min_valid    <= MIN_VALID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  a_steps_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_q.backup_steps != '0)
    else $error("backup step count is zero");

  a_steps_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == CFG_BACKUP_STEPS && cfg_data_i[STEPS_W-1:0] != '0
    |=> cfg_q.backup_steps == $past(cfg_data_i[STEPS_W-1:0]))
    else $error("backup step write lost");

  a_threshold_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(cfg_q))
    else $error("configuration changed without a write");

endmodule

// ===== hdl/spsg_scan_tracker.sv =====
// Scan state and decision logic: running minimum, backup countdown and result bundle.
// Depends on spsg_pkg for types and constants.
module spsg_scan_tracker #(
  parameter int unsigned MAX_SAMPLES = spsg_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SIDE_MARGIN = spsg_pkg::SIDE_MARGIN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  spsg_pkg::req_t    req_i,
  input  spsg_pkg::cfg_t    cfg_i,
  output logic              push_o,
  output spsg_pkg::bundle_t bundle_o
);
  import spsg_pkg::*;

  localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned POS_W    = CNT_W + 1;
  localparam int unsigned MARGIN_W = $clog2(SIDE_MARGIN + 1);
  localparam int unsigned CMP_W    = ((CNT_W > MARGIN_W) ? CNT_W : MARGIN_W) + 2;

  logic                      backing_q, backing_d;
  logic [STEPS_W-1:0]        left_q, left_d;
  logic [RANGE_W-1:0]        min_q, min_d;
  logic signed [POS_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  logic [RANGE_W-1:0]        min_new;
  logic signed [POS_W-1:0]   pos_new;
  logic [CNT_W-1:0]          cnt_new;
  logic [CNT_W-1:0]          mid;
  logic signed [CMP_W-1:0]   mid_s, pos_s, margin_s;
  side_e                     side;
  logic                      is_range;

  assign is_range = (req_i.req_type == REQ_RANGE);

  // Running minimum including the current sample.
  always_comb begin
    min_new = min_q;
    pos_new = pos_q;
    cnt_new = cnt_q;
    if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
      if (req_i.range_sample > cfg_i.min_valid && req_i.range_sample < min_q) begin
        min_new = req_i.range_sample;
        pos_new = $signed({1'b0, cnt_q});
      end
      cnt_new = cnt_q + CNT_W'(1);
    end
  end

  // Side of the nearest beam relative to mid-scan.
  assign mid      = cnt_new >> 1;
  assign mid_s    = $signed({{(CMP_W - CNT_W){1'b0}}, mid});
  assign pos_s    = {{(CMP_W - POS_W){pos_new[POS_W-1]}}, pos_new};
  assign margin_s = $signed(CMP_W'(SIDE_MARGIN));

  always_comb begin
    if (pos_s > mid_s + margin_s) begin
      side = SIDE_LEFT;
    end else if (pos_s < mid_s - margin_s) begin
      side = SIDE_RIGHT;
    end else begin
      side = SIDE_FRONT;
    end
  end

  always_comb begin
    backing_d = backing_q;
    left_d    = left_q;
    min_d     = min_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    push_o    = 1'b0;

    bundle_o.cnt       = 2'd1;
    bundle_o.slot      = '{SLOT_INFO, SLOT_INFO, SLOT_PASS};
    bundle_o.lin_x     = req_i.cmd_lin_x;
    bundle_o.lin_y     = req_i.cmd_lin_y;
    bundle_o.lin_z     = req_i.cmd_lin_z;
    bundle_o.ang_x     = req_i.cmd_ang_x;
    bundle_o.ang_y     = req_i.cmd_ang_y;
    bundle_o.ang_z     = req_i.cmd_ang_z;
    bundle_o.nearest   = min_new;
    bundle_o.threshold = cfg_i.threshold;
    bundle_o.side      = side;

    if (accept_i) begin
      if (!is_range) begin
        push_o = !backing_q;
      end else begin
        min_d = min_new;
        pos_d = pos_new;
        cnt_d = cnt_new;
        if (req_i.scan_end) begin
          push_o = 1'b1;
          if (backing_q && left_q != '0) begin
            left_d = left_q - STEPS_W'(1);
            if (left_q == STEPS_W'(1)) begin
              backing_d     = 1'b0;
              bundle_o.cnt  = 2'd3;
              bundle_o.slot = '{SLOT_INFO, SLOT_STOP, SLOT_REVERSE};
            end else begin
              bundle_o.cnt  = 2'd2;
              bundle_o.slot = '{SLOT_INFO, SLOT_INFO, SLOT_REVERSE};
            end
          end else if (!backing_q && min_new < cfg_i.threshold) begin
            backing_d     = 1'b1;
            left_d        = cfg_i.backup_steps;
            bundle_o.cnt  = 2'd2;
            bundle_o.slot = '{SLOT_INFO, SLOT_INFO, SLOT_REVERSE};
          end else begin
            bundle_o.cnt  = 2'd1;
            bundle_o.slot = '{SLOT_INFO, SLOT_INFO, SLOT_INFO};
          end
          min_d = NO_RANGE_MM;
          pos_d = '1;
          cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backing_q <= 1'b0;
      left_q    <= '0;
      min_q     <= NO_RANGE_MM;
      pos_q     <= '1;
      cnt_q     <= '0;
    end else begin
      backing_q <= backing_d;
      left_q    <= left_d;
      min_q     <= min_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
    end
  end

  a_backing_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    backing_q |-> left_q != '0)
    else $error("backup active with zero steps left");

  a_pos_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == '1 || $signed({1'b0, cnt_q}) > pos_q)
    else $error("minimum index outside the samples seen");

  a_no_cmd_in_backup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && !is_range |-> !backing_q)
    else $error("command passed during backup");

  a_scan_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_range && req_i.scan_end |=> cnt_q == '0 && min_q == NO_RANGE_MM)
    else $error("scan state not cleared at scan end");

endmodule

// ===== hdl/spsg_result_queue.sv =====
// Two-entry bundle queue; bundle results leave one per cycle while take_i is high.
// Depends on spsg_pkg for the bundle and result types.
module spsg_result_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spsg_pkg::bundle_t bundle_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              take_i,
  output spsg_pkg::res_t    res_o
);
  import spsg_pkg::*;

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q, fill_d;
  logic [1:0] slot_q, slot_d;
  bundle_t    head;
  slot_e      cur;
  logic       last, pop;

  assign head    = mem_q[rd_q];
  assign cur     = head.slot[slot_q];
  assign valid_o = (fill_q != 2'd0);
  assign ready_o = (fill_q != 2'd2);
  assign last    = (slot_q == head.cnt - 2'd1);
  assign pop     = valid_o && take_i && last;

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
    slot_d = slot_q;
    if (valid_o && take_i) begin
      slot_d = last ? 2'd0 : slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
      slot_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
      slot_q <= slot_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  always_comb begin
    res_o                = '0;
    res_o.run_last       = last;
    case (cur)
      SLOT_PASS: begin
        res_o.out_kind    = KIND_DRIVE;
        res_o.drive_lin_x = head.lin_x;
        res_o.drive_lin_y = head.lin_y;
        res_o.drive_lin_z = head.lin_z;
        res_o.drive_ang_x = head.ang_x;
        res_o.drive_ang_y = head.ang_y;
        res_o.drive_ang_z = head.ang_z;
      end
      SLOT_REVERSE: begin
        res_o.out_kind    = KIND_DRIVE;
        res_o.drive_lin_x = REVERSE_MMS;
      end
      SLOT_STOP: begin
        res_o.out_kind    = KIND_DRIVE;
      end
      SLOT_INFO: begin
        res_o.out_kind       = KIND_INFO;
        res_o.nearest_mm     = head.nearest;
        res_o.threshold_echo = head.threshold;
        res_o.obstacle_side  = head.side;
      end
      default: res_o.out_kind = KIND_DRIVE;
    endcase
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> fill_q != 2'd2)
    else $error("bundle pushed into a full queue");

  a_slot_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> head.cnt != 2'd0 && slot_q < head.cnt)
    else $error("result slot outside its bundle");

  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> slot_q == 2'd0)
    else $error("slot counter moved with an empty queue");

endmodule

// ===== hdl/scan_proximity_safety_gate_core.sv =====
// Top level of the scan proximity safety gate.
// Depends on spsg_pkg, the channels in spsg_if, spsg_cfg_regs, spsg_scan_tracker and
// spsg_result_queue.

// The gate takes one item per cycle on req_i unless stalled: a velocity command
// (req_type 0) or one lidar beam range (req_type 1). A command goes straight out as a
// drive result unless a backup is active, in which case it is dropped. Range samples
// keep the scan's minimum and its beam index; the sample flagged scan_end closes the
// scan and makes one to three results: an optional reverse command (lin_x -300 mm/s),
// a stop command when the last backup step runs out, and always an obstacle info
// result with the minimum, the threshold and the side of the nearest beam. run_last
// marks the final result of each item. All decisions for an item are made in the
// cycle it is taken, so state updates never wait on the output. The results go into
// a two-entry queue and leave one per cycle while res_o.ready is high, so an item
// that makes one result keeps the rate at one item per cycle, and a scan end that
// makes k results hands them out in turn; req_i.ready drops only while the queue
// holds two unfinished items. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i and takes effect on the next item; write it only while the block is idle.
module scan_proximity_safety_gate_core #(
  parameter int unsigned MAX_SAMPLES = spsg_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SIDE_MARGIN = spsg_pkg::SIDE_MARGIN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spsg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  spsg_req_if.sink                        req_i,
  spsg_res_if.source                      res_o
);
  import spsg_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    accept;
  logic    push;
  logic    queue_ready;

  // An item is taken whenever the queue has a free entry.
  assign req_i.ready = queue_ready;
  assign accept      = req_i.valid && queue_ready;

  spsg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Scan tracking and the backup decision, done in the accepting cycle.
  spsg_scan_tracker #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SIDE_MARGIN (SIDE_MARGIN)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i.data),
    .cfg_i    (cfg),
    .push_o   (push),
    .bundle_o (bundle)
  );

  // Results of each item are queued and handed out one at a time.
  spsg_result_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .ready_o  (queue_ready),
    .valid_o  (res_o.valid),
    .take_i   (res_o.ready),
    .res_o    (res_o.data)
  );

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> accept)
    else $error("result bundle without an accepted item");

  a_ready_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready && res_o.valid && res_o.ready && res_o.data.run_last |=> req_i.ready)
    else $error("queue entry not freed after its last result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.data))
    else $error("stalled result changed");

endmodule
